// ----- sv/asc_pkg.sv -----
// Shared constants, beat types, command codes and helpers for the ADC scan calibrator.
`timescale 1ns / 1ps

package asc_pkg;

    localparam int SCAN_LENGTH    = 6;
    localparam int STORE_CHANNELS = 8;
    localparam int SAMPLE_BITS    = 10;

    localparam int CH_W       = 3;
    localparam int POS_W      = 3;
    localparam int ROUNDS_W   = 8;
    localparam int ORDER_W    = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam int N_OUT      = (STORE_CHANNELS < 8) ? STORE_CHANNELS : 8;
    localparam int IDX_W      = $clog2(STORE_CHANNELS);
    localparam int SUM_W      = SAMPLE_BITS + 8;
    localparam int DIVIDEND_W = SUM_W + 1;
    localparam int REM_W      = ROUNDS_W;
    localparam int DCNT_W     = $clog2(DIVIDEND_W);

    typedef enum logic [1:0] {
        CMD_CONV  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_CALIB = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDERED_MODE  = 1'b0,
        REG_CHANNEL_ORDER = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        cmd_t                   command;
        logic [SAMPLE_BITS-1:0] sample;
        logic [ROUNDS_W-1:0]    calib_rounds;
    } in_beat_t;

    typedef struct packed {
        logic [CH_W-1:0]        next_channel;
        logic [ROUNDS_W-1:0]    round_count;
        logic                   calibrating;
        logic [CH_W-1:0]        channel_index;
        logic [SAMPLE_BITS-1:0] channel_value;
        logic [SAMPLE_BITS-1:0] channel_offset;
        logic                   last;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic             accept;
        logic             exec;
        logic             round;
        logic             div_load;
        logic             div_step;
        logic             div_store;
        logic             calib_done;
        logic             load_single;
        logic             load_emit;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_conv;
        logic wrap;
        logic calib_finish;
        logic out_free;
    } dp_stat_t;

    function automatic logic [CH_W-1:0] chan_of(input logic mode,
                                                 input logic [ORDER_W-1:0] order,
                                                 input logic [POS_W-1:0] pos);
        logic [3*8-1:0] ext;
        ext = {{(3*8-ORDER_W){1'b0}}, order};
        return mode ? ext[3*int'(pos) +: CH_W] : pos;
    endfunction

endpackage

// ----- sv/adc_scan_snapshot_calibrator.sv -----
// Top level of the ADC round-robin scan calibrator.
// Usage:
//   item channel (item_valid/item_stall/item) takes one command beat at a time:
//   a conversion result, a round counter clear or a calibration start.
//   result channel (result_valid/result_stall/result) returns the result beats;
//   last marks the final beat caused by one command.
//   cfg_write/cfg_index/cfg_data write ordered_mode (0) and channel_order (1);
//   write only while no command is in flight.
// Timing:
//   one command is worked at a time by the state machine. A status command or a
//   conversion that does not end a round goes from idle through exec and single.
//   A conversion that ends a round goes through round and emit, giving 8 beats.
//   The round that ends a calibration first divides all 8 channels in the shared
//   bit-serial divider (load, 19 quotient bits and store per channel).
//   The result register holds one beat; a new command is accepted while that
//   beat still waits. When the receiver stalls, the sequencer waits at the
//   register and item_stall stays high until its last beat is loaded there.
// Reset: stores, counters and position clear, ordered_mode returns to 1,
//   no beat is pending, and the block is ready at once.
`timescale 1ns / 1ps

module adc_scan_snapshot_calibrator
    import asc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_beat_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_beat_t             result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    asc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    asc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ----- sv/asc_ctrl.sv -----
// Sequencing state machine for the ADC scan calibrator.
`timescale 1ns / 1ps

module asc_ctrl
    import asc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_EXEC      = 8'b0000_0010,
        S_ROUND     = 8'b0000_0100,
        S_DIV_LOAD  = 8'b0000_1000,
        S_DIV_STEP  = 8'b0001_0000,
        S_DIV_STORE = 8'b0010_0000,
        S_EMIT      = 8'b0100_0000,
        S_SINGLE    = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [DCNT_W-1:0]  bit_reg, bit_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_conv && stat.wrap)
                    state_next = S_ROUND;
                else
                    state_next = S_SINGLE;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                idx_next   = '0;
                state_next = stat.calib_finish ? S_DIV_LOAD : S_EMIT;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                bit_next     = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == DCNT_W'(DIVIDEND_W - 1))
                    state_next = S_DIV_STORE;
            end
            S_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                if (idx_reg == IDX_W'(STORE_CHANNELS - 1))
                begin
                    cmd.calib_done = 1'b1;
                    idx_next       = '0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DIV_LOAD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_emit = 1'b1;
                    if (idx_reg == IDX_W'(N_OUT - 1))
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_EXEC)
        else $error("accepted beat not executed next cycle");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_STEP |-> bit_reg < DCNT_W'(DIVIDEND_W))
        else $error("divider step count overrun");

    a_round_follow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |=> (state_reg == S_DIV_LOAD || state_reg == S_EMIT))
        else $error("round update not followed by divide or emit");

endmodule

// ----- sv/asc_dp.sv -----
// Stores, scan position, calibration accumulators, divider and result register.
`timescale 1ns / 1ps

module asc_dp
    import asc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_beat_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_beat_t             result,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    logic                   ordered_mode_reg;
    logic [ORDER_W-1:0]     channel_order_reg;
    logic [SAMPLE_BITS-1:0] working_reg  [STORE_CHANNELS];
    logic [SAMPLE_BITS-1:0] snapshot_reg [STORE_CHANNELS];
    logic [SAMPLE_BITS-1:0] offset_reg   [STORE_CHANNELS];
    logic [SUM_W-1:0]       sum_reg      [STORE_CHANNELS];
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [ROUNDS_W-1:0]    rounds_reg;
    logic                   active_reg;
    logic [ROUNDS_W-1:0]    target_reg;
    logic [ROUNDS_W-1:0]    progress_reg, progress_next;
    in_beat_t               in_reg;
    logic [CH_W-1:0]        conv_ch_reg;
    logic [REM_W-1:0]       div_rem_reg, div_rem_next;
    logic [DIVIDEND_W-1:0]  div_quo_reg;
    logic                   div_bit;
    logic [REM_W:0]         trial;
    logic [REM_W:0]         diff;
    out_beat_t              out_reg, out_next;
    logic                   out_valid_reg;
    logic [CH_W-1:0]        cur_ch;
    logic                   cur_in_store;
    logic                   conv_in_store;
    logic                   calib_start;

    assign cur_ch        = chan_of(ordered_mode_reg, channel_order_reg, pos_reg);
    assign cur_in_store  = 32'(cur_ch) < STORE_CHANNELS;
    assign conv_in_store = 32'(conv_ch_reg) < STORE_CHANNELS;
    assign pos_next      = stat.wrap ? '0 : pos_reg + 1'b1;
    assign progress_next = progress_reg + 1'b1;
    assign calib_start   = (in_reg.command == CMD_CALIB) && (in_reg.calib_rounds != '0);

    assign stat.is_conv      = (in_reg.command == CMD_CONV);
    assign stat.wrap         = 32'(pos_reg) + 1 >= SCAN_LENGTH;
    assign stat.calib_finish = active_reg && (progress_next >= target_reg);
    assign stat.out_free     = !out_valid_reg || !result_stall;

    // restoring divider, one quotient bit per step
    assign trial        = {div_rem_reg, div_quo_reg[DIVIDEND_W-1]};
    assign diff         = trial - {1'b0, target_reg};
    assign div_bit      = (trial >= {1'b0, target_reg});
    assign div_rem_next = div_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_mode_reg  <= 1'b1;
            channel_order_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORDERED_MODE:  ordered_mode_reg  <= cfg_data[0];
                REG_CHANNEL_ORDER: channel_order_reg <= cfg_data[ORDER_W-1:0];
                default:           ordered_mode_reg  <= ordered_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            in_reg <= item;
        if (cmd.exec)
            conv_ch_reg <= cur_ch;
        if (cmd.div_load)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= DIVIDEND_W'(sum_reg[cmd.idx]) + DIVIDEND_W'(target_reg >> 1);
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= {div_quo_reg[DIVIDEND_W-2:0], div_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_CHANNELS; i++)
            begin
                working_reg[i]  <= '0;
                snapshot_reg[i] <= '0;
                offset_reg[i]   <= '0;
                sum_reg[i]      <= '0;
            end
            pos_reg      <= '0;
            rounds_reg   <= '0;
            active_reg   <= 1'b0;
            target_reg   <= ROUNDS_W'(1);
            progress_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                unique case (in_reg.command)
                    CMD_CONV:
                    begin
                        if (cur_in_store)
                            working_reg[IDX_W'(cur_ch)] <= in_reg.sample;
                        pos_reg <= pos_next;
                    end
                    CMD_CLEAR:
                    begin
                        rounds_reg <= '0;
                    end
                    CMD_CALIB:
                    begin
                        if (calib_start)
                        begin
                            for (int i = 0; i < STORE_CHANNELS; i++)
                                sum_reg[i] <= '0;
                            progress_reg <= '0;
                            target_reg   <= in_reg.calib_rounds;
                            active_reg   <= 1'b1;
                            rounds_reg   <= '0;
                        end
                    end
                    CMD_NOP:
                    begin
                        rounds_reg <= rounds_reg;
                    end
                    default:
                    begin
                        rounds_reg <= rounds_reg;
                    end
                endcase
            end
            if (cmd.round)
            begin
                for (int i = 0; i < STORE_CHANNELS; i++)
                    snapshot_reg[i] <= working_reg[i];
                rounds_reg <= rounds_reg + 1'b1;
                if (active_reg)
                begin
                    for (int i = 0; i < STORE_CHANNELS; i++)
                        sum_reg[i] <= sum_reg[i] + SUM_W'(working_reg[i]);
                    progress_reg <= progress_next;
                end
            end
            if (cmd.div_store)
                offset_reg[cmd.idx] <= div_quo_reg[SAMPLE_BITS-1:0];
            if (cmd.calib_done)
                active_reg <= 1'b0;
        end
    end

    always_comb
    begin
        out_next              = out_reg;
        out_next.next_channel = cur_ch;
        out_next.round_count  = rounds_reg;
        out_next.calibrating  = active_reg;
        if (cmd.load_emit)
        begin
            out_next.channel_index  = CH_W'(cmd.idx);
            out_next.channel_value  = snapshot_reg[cmd.idx];
            out_next.channel_offset = offset_reg[cmd.idx];
            out_next.last           = (cmd.idx == IDX_W'(N_OUT - 1));
        end
        else
        begin
            out_next.last = 1'b1;
            if (stat.is_conv)
            begin
                out_next.channel_index  = conv_ch_reg;
                out_next.channel_value  = in_reg.sample;
                out_next.channel_offset = conv_in_store ?
                                          offset_reg[IDX_W'(conv_ch_reg)] : '0;
            end
            else
            begin
                out_next.channel_index  = '0;
                out_next.channel_value  = '0;
                out_next.channel_offset = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_emit || cmd.load_single)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_emit || cmd.load_single)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_emit || cmd.load_single) |-> stat.out_free)
        else $error("result register overwritten while held");

    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> active_reg && target_reg != '0)
        else $error("divide started without active calibration");

    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |-> pos_reg == '0)
        else $error("round update without scan wrap");

endmodule
